/* src/aleu_pkg.sv */
// Shared types, field widths and codes of the adjacency list edge update unit.
`timescale 1ns / 1ps

package aleu_pkg;

   // Fixed field widths of the request and response transfers
   localparam int OPCODE_W     = 2;
   localparam int NODE_FIELD_W = 6;
   localparam int SLOT_FIELD_W = 4;
   localparam int STATUS_W     = 3;
   localparam int DEG_FIELD_W  = 5;
   localparam int NB_FIELD_W   = 6;
   localparam int NODE_FIELD_N = 1 << NODE_FIELD_W;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 24;

   // Default configuration
   localparam int DEF_NODE_COUNT = 64;
   localparam int DEF_MAX_DEGREE = 16;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [1:0]          alu_op_type;

   localparam opcode_type OP_ADD  = 2'd0;
   localparam opcode_type OP_DEL  = 2'd1;
   localparam opcode_type OP_READ = 2'd2;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_PRESENT = 3'd1;
   localparam status_type ST_ABSENT  = 3'd2;
   localparam status_type ST_FULL    = 3'd3;
   localparam status_type ST_UNUSED  = 3'd4;
   localparam status_type ST_SELF    = 3'd5;

   // Shared degree unit operations
   localparam alu_op_type ALU_PASS = 2'd0;
   localparam alu_op_type ALU_INC  = 2'd1;
   localparam alu_op_type ALU_DEC  = 2'd2;

endpackage

/* src/adjacency_list_edge_update_unit.sv */
// Top level of the adjacency list edge update unit: sequencer, memories, shared unit.
`timescale 1ns / 1ps

// Keeps an undirected graph as per-node neighbor lists, a degree store and a
// node-by-node slot map. Requests arrive on the req_ stream (add edge, delete
// edge with swap-remove, read neighbor slot); each gives one response transfer
// on the rsp_ stream with a status code and the resulting degrees.
// One request is in flight at a time; req_tready is high only while idle.
// Each request steps through RD_A, RD_B and EVAL, then DONE for reads and rejected
// operations, ADD_A and ADD_B before DONE for a successful add, or DEL_A1, DEL_A2,
// DEL_B1 and DEL_B2 before DONE for a successful delete; DONE returns to IDLE. The
// sequence is set by the single write port of the slot map and neighbor memories
// (each endpoint needs its own write states) and their registered reads.
// The response sits in an output register: the sequencer may accept the next
// request while it waits; a stalled receiver only holds the next result back
// in its final state until the register frees.
// After reset the slot map (and the degree store alongside) is swept to
// absent/zero, one entry per cycle. No request is taken during that sweep.
module adjacency_list_edge_update_unit
   import aleu_pkg::*;
#(
   parameter int NODE_COUNT = DEF_NODE_COUNT,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[1:0], node_a[7:2], node_b[13:8], slot[17:14], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], degree_a[7:3], degree_b[12:8], neighbour[18:13], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
   localparam int UW     = (DEG_W > SLOT_FIELD_W) ? DEG_W : SLOT_FIELD_W;
   localparam int SM_AW  = 2 * NODE_W;
   localparam int SM_W   = 1 + SLOT_W;
   localparam int NL_AW  = NODE_W + SLOT_W;

   // Sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RD_A   = 4'd2;
   localparam logic [3:0] S_RD_B   = 4'd3;
   localparam logic [3:0] S_EVAL   = 4'd4;
   localparam logic [3:0] S_ADD_A  = 4'd5;
   localparam logic [3:0] S_ADD_B  = 4'd6;
   localparam logic [3:0] S_DEL_A1 = 4'd7;
   localparam logic [3:0] S_DEL_A2 = 4'd8;
   localparam logic [3:0] S_DEL_B1 = 4'd9;
   localparam logic [3:0] S_DEL_B2 = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   // Request field split
   opcode_type              req_opcode;
   logic [NODE_FIELD_W-1:0] req_node_a;
   logic [NODE_FIELD_W-1:0] req_node_b;
   logic [SLOT_FIELD_W-1:0] req_slot;

   assign req_opcode = req_tdata[1:0];
   assign req_node_a = req_tdata[7:2];
   assign req_node_b = req_tdata[13:8];
   assign req_slot   = req_tdata[17:14];

   // Node field folded into range (constant table)
   logic [NODE_W-1:0] node_map [NODE_FIELD_N];

   for (genvar gi = 0; gi < NODE_FIELD_N; gi++) begin : g_node_map
      assign node_map[gi] = NODE_W'(gi % NODE_COUNT);
   end

   logic [NODE_W-1:0] map_a;
   logic [NODE_W-1:0] map_b;

   assign map_a = node_map[req_node_a];
   assign map_b = node_map[req_node_b];

   // Control and holding registers
   logic [3:0]              state_ff, state_in;
   logic [SM_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   opcode_type              op_ff, op_in;
   logic [NODE_W-1:0]       a_ff, a_in;
   logic [NODE_W-1:0]       b_ff, b_in;
   logic [SLOT_FIELD_W-1:0] s_ff, s_in;
   logic [DEG_W-1:0]        deg_a_ff, deg_a_in;
   logic [DEG_W-1:0]        deg_b_ff, deg_b_in;
   logic [SM_W-1:0]         sm_ab_ff, sm_ab_in;
   logic [SM_W-1:0]         sm_ba_ff, sm_ba_in;
   logic [NODE_W-1:0]       nl_as_ff, nl_as_in;
   logic [UW-1:0]           alu_a_ff, alu_a_in;
   logic [UW-1:0]           alu_b_ff, alu_b_in;
   logic                    lt_a_ff, lt_a_in;
   logic                    lt_b_ff, lt_b_in;
   logic [NODE_W-1:0]       moved_a_ff, moved_a_in;
   logic [NODE_W-1:0]       moved_b_ff, moved_b_in;
   status_type              status_ff, status_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   // Memory ports
   logic               deg_we;
   logic [NODE_W-1:0]  deg_waddr, deg_raddr;
   logic [DEG_W-1:0]   deg_wdata, deg_rdata;
   logic               sm_we;
   logic [SM_AW-1:0]   sm_waddr, sm_raddr;
   logic [SM_W-1:0]    sm_wdata, sm_rdata;
   logic               nl_we;
   logic [NL_AW-1:0]   nl_waddr, nl_raddr;
   logic [NODE_W-1:0]  nl_wdata, nl_rdata;

   // Shared unit
   alu_op_type    alu_op;
   logic [UW-1:0] alu_x, alu_y, alu_result;
   logic          alu_less;

   aleu_alu #(
      .WIDTH (UW)
   ) u_alu (
      .op     (alu_op),
      .opnd_x (alu_x),
      .opnd_y (alu_y),
      .result (alu_result),
      .less   (alu_less)
   );

   aleu_ram #(
      .WIDTH (DEG_W),
      .DEPTH (1 << NODE_W)
   ) u_deg_ram (
      .clock (clock),
      .we    (deg_we),
      .waddr (deg_waddr),
      .wdata (deg_wdata),
      .raddr (deg_raddr),
      .rdata (deg_rdata)
   );

   aleu_ram #(
      .WIDTH (SM_W),
      .DEPTH (1 << SM_AW)
   ) u_slot_map_ram (
      .clock (clock),
      .we    (sm_we),
      .waddr (sm_waddr),
      .wdata (sm_wdata),
      .raddr (sm_raddr),
      .rdata (sm_rdata)
   );

   aleu_ram #(
      .WIDTH (NODE_W),
      .DEPTH (1 << NL_AW)
   ) u_nbr_list_ram (
      .clock (clock),
      .we    (nl_we),
      .waddr (nl_waddr),
      .wdata (nl_wdata),
      .raddr (nl_raddr),
      .rdata (nl_rdata)
   );

   // Slot map entry: valid in MSB, slot below
   logic              ab_valid, ba_valid, op_done_ok, edge_op;
   logic [SLOT_W-1:0] freed_a, freed_b;

   assign ab_valid = sm_ab_ff[SM_W-1];
   assign ba_valid = sm_ba_ff[SM_W-1];
   assign freed_a  = sm_ab_ff[SLOT_W-1:0];
   assign freed_b  = sm_ba_ff[SLOT_W-1:0];
   assign edge_op  = (op_ff == OP_ADD) || (op_ff == OP_DEL);
   assign op_done_ok = (status_ff == ST_OK) && edge_op;

   // Shared unit operand select: RD_A works on node_a, RD_B on node_b
   always_comb begin
      alu_op = ALU_PASS;
      alu_x  = UW'(deg_rdata);
      alu_y  = UW'(MAX_DEGREE);
      case (op_ff)
         OP_ADD:  alu_op = ALU_INC;   // less flags room for one more edge
         OP_DEL:  alu_op = ALU_DEC;
         OP_READ: begin
            if (state_ff == S_RD_A) begin
               alu_x = UW'(s_ff);     // slot below degree?
               alu_y = UW'(deg_rdata);
            end
         end
         default: alu_op = ALU_PASS;
      endcase
   end

   // Memory addressing per state
   always_comb begin
      deg_raddr = b_ff;
      sm_raddr  = {b_ff, a_ff};
      nl_raddr  = {b_ff, alu_b_ff[SLOT_W-1:0]};
      deg_we    = 1'b0;
      deg_waddr = a_ff;
      deg_wdata = alu_a_ff[DEG_W-1:0];
      sm_we     = 1'b0;
      sm_waddr  = {a_ff, b_ff};
      sm_wdata  = '0;
      nl_we     = 1'b0;
      nl_waddr  = {a_ff, deg_a_ff[SLOT_W-1:0]};
      nl_wdata  = b_ff;
      case (state_ff)
         S_CLEAR: begin
            deg_we    = 1'b1;
            deg_waddr = clr_cnt_ff[NODE_W-1:0];
            deg_wdata = '0;
            sm_we     = 1'b1;
            sm_waddr  = clr_cnt_ff;
         end
         S_IDLE: begin
            deg_raddr = map_a;
            sm_raddr  = {map_a, map_b};
            nl_raddr  = {map_a, SLOT_W'(req_slot)};
         end
         S_RD_B: begin
            // last neighbor of node_a after the decrement
            nl_raddr = {a_ff, alu_a_ff[SLOT_W-1:0]};
         end
         S_ADD_A: begin
            deg_we   = 1'b1;
            sm_we    = 1'b1;
            sm_wdata = {1'b1, deg_a_ff[SLOT_W-1:0]};
            nl_we    = 1'b1;
         end
         S_ADD_B: begin
            deg_we    = 1'b1;
            deg_waddr = b_ff;
            deg_wdata = alu_b_ff[DEG_W-1:0];
            sm_we     = 1'b1;
            sm_waddr  = {b_ff, a_ff};
            sm_wdata  = {1'b1, deg_b_ff[SLOT_W-1:0]};
            nl_we     = 1'b1;
            nl_waddr  = {b_ff, deg_b_ff[SLOT_W-1:0]};
            nl_wdata  = a_ff;
         end
         S_DEL_A1: begin
            deg_we   = 1'b1;
            sm_we    = 1'b1;
            sm_waddr = {a_ff, moved_a_ff};
            sm_wdata = {1'b1, freed_a};
            nl_we    = 1'b1;
            nl_waddr = {a_ff, freed_a};
            nl_wdata = moved_a_ff;
         end
         S_DEL_A2: begin
            sm_we = 1'b1;   // removed pair goes absent, also when it was the moved one
         end
         S_DEL_B1: begin
            deg_we    = 1'b1;
            deg_waddr = b_ff;
            deg_wdata = alu_b_ff[DEG_W-1:0];
            sm_we     = 1'b1;
            sm_waddr  = {b_ff, moved_b_ff};
            sm_wdata  = {1'b1, freed_b};
            nl_we     = 1'b1;
            nl_waddr  = {b_ff, freed_b};
            nl_wdata  = moved_b_ff;
         end
         S_DEL_B2: begin
            sm_we    = 1'b1;
            sm_waddr = {b_ff, a_ff};
         end
         default: begin
            deg_we = 1'b0;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      s_in          = s_ff;
      deg_a_in      = deg_a_ff;
      deg_b_in      = deg_b_ff;
      sm_ab_in      = sm_ab_ff;
      sm_ba_in      = sm_ba_ff;
      nl_as_in      = nl_as_ff;
      alu_a_in      = alu_a_ff;
      alu_b_in      = alu_b_ff;
      lt_a_in       = lt_a_ff;
      lt_b_in       = lt_b_ff;
      moved_a_in    = moved_a_ff;
      moved_b_in    = moved_b_ff;
      status_in     = status_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + SM_AW'(1);
            if (&clr_cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_opcode;
               a_in     = map_a;
               b_in     = map_b;
               s_in     = req_slot;
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            deg_a_in = deg_rdata;
            sm_ab_in = sm_rdata;
            nl_as_in = nl_rdata;
            alu_a_in = alu_result;
            lt_a_in  = alu_less;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            deg_b_in = deg_rdata;
            sm_ba_in = sm_rdata;
            alu_b_in = alu_result;
            lt_b_in  = alu_less;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            moved_a_in = nl_rdata;
            case (op_ff)
               OP_ADD: begin
                  if (a_ff == b_ff) begin
                     status_in = ST_SELF;
                  end else if (ab_valid) begin
                     status_in = ST_PRESENT;
                  end else if (!lt_a_ff || !lt_b_ff) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_OK;
                  end
               end
               OP_DEL: begin
                  if (a_ff == b_ff) begin
                     status_in = ST_SELF;
                  end else if (!ab_valid || !ba_valid || (deg_a_ff == '0)
                               || (deg_b_ff == '0)) begin
                     status_in = ST_ABSENT;
                  end else begin
                     status_in = ST_OK;
                  end
               end
               OP_READ: status_in = lt_a_ff ? ST_OK : ST_UNUSED;
               default: status_in = ST_OK;
            endcase
            state_in = S_DONE;
            if (status_in == ST_OK) begin
               if (op_ff == OP_ADD) begin
                  state_in = S_ADD_A;
               end else if (op_ff == OP_DEL) begin
                  state_in = S_DEL_A1;
               end
            end
         end
         S_ADD_A:  state_in = S_ADD_B;
         S_ADD_B:  state_in = S_DONE;
         S_DEL_A1: begin
            moved_b_in = nl_rdata;
            state_in   = S_DEL_A2;
         end
         S_DEL_A2: state_in = S_DEL_B1;
         S_DEL_B1: state_in = S_DEL_B2;
         S_DEL_B2: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[2:0] = status_ff;
               rsp_tdata_in[7:3] = op_done_ok ? DEG_FIELD_W'(alu_a_ff[DEG_W-1:0])
                                              : DEG_FIELD_W'(deg_a_ff);
               if (op_ff != OP_READ) begin
                  rsp_tdata_in[12:8] = op_done_ok ? DEG_FIELD_W'(alu_b_ff[DEG_W-1:0])
                                                  : DEG_FIELD_W'(deg_b_ff);
               end
               if ((op_ff == OP_READ) && (status_ff == ST_OK)) begin
                  rsp_tdata_in[18:13] = NB_FIELD_W'(nl_as_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      s_ff         <= s_in;
      deg_a_ff     <= deg_a_in;
      deg_b_ff     <= deg_b_in;
      sm_ab_ff     <= sm_ab_in;
      sm_ba_ff     <= sm_ba_in;
      nl_as_ff     <= nl_as_in;
      alu_a_ff     <= alu_a_in;
      alu_b_ff     <= alu_b_in;
      lt_a_ff      <= lt_a_in;
      lt_b_ff      <= lt_b_in;
      moved_a_ff   <= moved_a_in;
      moved_b_ff   <= moved_b_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(deg_we || sm_we || nl_we))
      else $error("memory write while idle");

   a_degree_bound: assert property (@(posedge clock) disable iff (reset)
      deg_we |-> (deg_wdata <= DEG_W'(MAX_DEGREE)))
      else $error("degree written above maximum");

   a_add_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_A) |-> ((deg_a_ff < DEG_W'(MAX_DEGREE))
                                 && (deg_b_ff < DEG_W'(MAX_DEGREE))))
      else $error("edge added at full degree");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside final state");

endmodule

/* src/aleu_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module aleu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/aleu_alu.sv */
// Shared degree unit: increment, decrement or pass, plus a less-than compare.
`timescale 1ns / 1ps

module aleu_alu
   import aleu_pkg::*;
#(
   parameter int WIDTH = 5
) (
   input  alu_op_type       op,
   input  logic [WIDTH-1:0] opnd_x,
   input  logic [WIDTH-1:0] opnd_y,
   output logic [WIDTH-1:0] result,
   output logic             less
);

   always_comb begin
      case (op)
         ALU_INC: result = opnd_x + WIDTH'(1);
         ALU_DEC: result = opnd_x - WIDTH'(1);
         default: result = opnd_x;
      endcase
   end

   assign less = (opnd_x < opnd_y);

endmodule

/* dv/edge_update_checker.sv */
// Stream monitor, edge store predictor and response comparison for the edge update unit.
`timescale 1ns / 1ps

module edge_update_checker
   import aleu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // opcode, node_a, node_b, slot, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, degree_a, degree_b, neighbour, zero fill
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     mismatch_count,
   output int                     pending_count
);

   localparam int NODE_N  = DEF_NODE_COUNT;
   localparam int MAX_DEG = DEF_MAX_DEGREE;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot;
      logic [NODE_FIELD_W-1:0] node_b;
      logic [NODE_FIELD_W-1:0] node_a;
      opcode_type              opcode;
   } edge_req_type;

   typedef struct packed {
      logic [NB_FIELD_W-1:0]  neighbour;
      logic [DEG_FIELD_W-1:0] degree_b;
      logic [DEG_FIELD_W-1:0] degree_a;
      status_type             status;
   } edge_rsp_type;

   // Mirror of the graph
   logic [DEG_FIELD_W-1:0]  node_degree [NODE_N];
   logic                    linked      [NODE_N][NODE_N];
   logic [SLOT_FIELD_W-1:0] link_slot   [NODE_N][NODE_N];
   logic [NODE_FIELD_W-1:0] adj_node    [NODE_N][MAX_DEG];

   edge_rsp_type expected_responses[$];
   int           errors = 0;

   assign mismatch_count = errors;

   // j goes into the first free slot of node i
   function automatic void attach(logic [NODE_FIELD_W-1:0] i, logic [NODE_FIELD_W-1:0] j);
      logic [SLOT_FIELD_W-1:0] d;
      d = node_degree[i][SLOT_FIELD_W-1:0];
      link_slot[i][j] = d;
      linked[i][j]    = 1'b1;
      adj_node[i][d]  = j;
      node_degree[i]  = node_degree[i] + 1'b1;
   endfunction

   // Swap-remove: last neighbor of i fills the slot that j leaves
   function automatic void detach(logic [NODE_FIELD_W-1:0] i, logic [NODE_FIELD_W-1:0] j);
      logic [SLOT_FIELD_W-1:0] last, freed;
      logic [NODE_FIELD_W-1:0] moved;
      node_degree[i]      = node_degree[i] - 1'b1;
      last                = node_degree[i][SLOT_FIELD_W-1:0];
      moved               = adj_node[i][last];
      freed               = link_slot[i][j];
      link_slot[i][moved] = freed;
      adj_node[i][freed]  = moved;
      linked[i][j]        = 1'b0;
   endfunction

   function automatic edge_rsp_type predict_edge_op(edge_req_type r);
      edge_rsp_type res;
      logic [NODE_FIELD_W-1:0] a, b;
      res = '0;
      a = r.node_a;
      b = r.node_b;
      res.status = ST_OK;
      case (r.opcode)
         OP_ADD: begin
            if (a == b)
               res.status = ST_SELF;
            else if (linked[a][b])
               res.status = ST_PRESENT;
            else if (node_degree[a] >= MAX_DEG || node_degree[b] >= MAX_DEG)
               res.status = ST_FULL;
            else begin
               attach(a, b);
               attach(b, a);
            end
         end
         OP_DEL: begin
            if (a == b)
               res.status = ST_SELF;
            else if (!linked[a][b] || !linked[b][a] ||
                     node_degree[a] == 0 || node_degree[b] == 0)
               res.status = ST_ABSENT;
            else begin
               detach(a, b);
               detach(b, a);
            end
         end
         OP_READ: begin
            if (r.slot >= node_degree[a])
               res.status = ST_UNUSED;
            else
               res.neighbour = adj_node[a][r.slot];
         end
         default: ; // unused opcode: no change, degrees reported
      endcase
      res.degree_a = node_degree[a];
      res.degree_b = (r.opcode == OP_READ) ? '0 : node_degree[b];
      return res;
   endfunction

   function automatic void flag_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      edge_rsp_type want, got;
      if (reset) begin
         for (int i = 0; i < NODE_N; i++) begin
            node_degree[i] = '0;
            for (int k = 0; k < NODE_N; k++) begin
               linked[i][k]    = 1'b0;
               link_slot[i][k] = '0;
            end
            for (int k = 0; k < MAX_DEG; k++)
               adj_node[i][k] = '0;
         end
         expected_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(edge_rsp_type)-1:0];
            if (expected_responses.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, actual %h",
                        $time, got);
            end else begin
               want = expected_responses.pop_front();
               flag_field("status",    int'(want.status),    int'(got.status));
               flag_field("degree_a",  int'(want.degree_a),  int'(got.degree_a));
               flag_field("degree_b",  int'(want.degree_b),  int'(got.degree_b));
               flag_field("neighbour", int'(want.neighbour), int'(got.neighbour));
            end
         end
         if (req_tvalid && req_tready)
            expected_responses.push_back(
               predict_edge_op(edge_req_type'(req_tdata[$bits(edge_req_type)-1:0])));
      end
      pending_count <= expected_responses.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
   import aleu_pkg::*;

   localparam opcode_type OP_NONE   = 2'd3;   // unassigned opcode
   localparam int         PHASE_N   = 334;    // random requests per phase
   localparam int         BLOCK_N   = 40;     // requests per pool / mix choice
   localparam int         HOLD_AT   = 850;    // response count that starts the long stall
   localparam int         HOLD_LEN  = 300;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatches;
   int pending;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   adjacency_list_edge_update_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   edge_update_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   function automatic logic [REQ_TDATA_W-1:0] pack_req(opcode_type op, int a, int b, int s);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[1:0]   = op;
      d[7:2]   = a[5:0];
      d[13:8]  = b[5:0];
      d[17:14] = s[3:0];
      return d;
   endfunction

   // Mostly from a small window so degrees climb toward full; sometimes anywhere
   function automatic int pick_node(int base, int span);
      if ($urandom_range(99) < 75)
         return base + $urandom_range(span - 1);
      return $urandom_range(63);
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] random_req(int base, int span, bit growing);
      int roll;
      opcode_type op;
      roll = $urandom_range(99);
      if (growing)
         op = (roll < 70) ? OP_ADD : (roll < 82) ? OP_DEL : (roll < 97) ? OP_READ : OP_NONE;
      else
         op = (roll < 20) ? OP_ADD : (roll < 75) ? OP_DEL : (roll < 95) ? OP_READ : OP_NONE;
      return pack_req(op, pick_node(base, span), pick_node(base, span), $urandom_range(15));
   endfunction

   // Called at a rising edge; returns at the edge where the transfer happens
   task automatic send(logic [REQ_TDATA_W-1:0] d);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sender stays quiet until every pending response has been taken
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Receiver: random back-pressure plus one long stall, counted here
   initial begin
      int taken;
      int hold_left;
      bit hold_done;
      taken     = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      int base, span;
      bit growing;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each opcode, self-loops, duplicates,
      // absent deletes, unused slots, swap-remove with a moved neighbor
      send(pack_req(OP_ADD,  0, 63, 15));
      send(pack_req(OP_ADD,  63, 0, 0));
      send(pack_req(OP_READ, 63, 0, 0));
      send(pack_req(OP_READ, 0, 63, 15));
      send(pack_req(OP_ADD,  0, 1, 0));
      send(pack_req(OP_ADD,  63, 1, 0));
      send(pack_req(OP_READ, 1, 0, 1));
      send(pack_req(OP_ADD,  5, 5, 0));
      send(pack_req(OP_DEL,  63, 63, 0));
      send(pack_req(OP_DEL,  1, 2, 0));
      send(pack_req(OP_NONE, 0, 63, 15));
      send(pack_req(OP_DEL,  0, 63, 0));
      send(pack_req(OP_READ, 0, 0, 0));
      send(pack_req(OP_READ, 63, 0, 0));
      send(pack_req(OP_DEL,  0, 63, 0));
      send(pack_req(OP_DEL,  1, 0, 0));
      send(pack_req(OP_DEL,  1, 63, 0));
      send(pack_req(OP_READ, 1, 0, 0));
      send(pack_req(OP_ADD,  62, 61, 0));
      send(pack_req(OP_READ, 62, 0, 0));
      send(pack_req(OP_NONE, 63, 63, 15));
      drain();

      // Random: receiver lazy, then sender lazy, then both eager
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct <= (phase == 0) ? 10 : (phase == 1) ? 80 : 0;
         rx_idle_pct <= (phase == 0) ? 80 : (phase == 1) ? 10 : 0;
         for (int n = 0; n < PHASE_N; n++) begin
            if (n % BLOCK_N == 0) begin
               span    = $urandom_range(3, 24);
               base    = $urandom_range(64 - span);
               growing = ($urandom_range(99) < 55);
            end
            send(random_req(base, span, growing));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
src/aleu_pkg.sv
src/aleu_ram.sv
src/aleu_alu.sv
src/adjacency_list_edge_update_unit.sv
dv/edge_update_checker.sv
dv/tb.sv
